// ===== rtl/rfpp_pkg.sv =====
// shared types, codes and a helper function for the ring fifo with peek and peak
package rfpp_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned IB_W    = 4;
    localparam int unsigned ROOM_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 5;

    typedef enum logic [1:0] {
        OP_PUT     = 2'd0,
        OP_GET     = 2'd1,
        OP_PEEK    = 2'd2,
        OP_RELEASE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_SIZE  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_BYTES = 2'd1;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // datapath to controller
    typedef struct packed {
        t_opcode op;
        logic    full;
        logic    empty;
        logic    put_too_long;
        logic    room_short;
    } t_dp_stat;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    exec;
        logic    wr_en;
        logic    wr_adv;
        logic    rd_adv;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    give_data;
        t_status status;
    } t_dp_cmd;

    // low n bytes set, n of eight or more gives all ones
    function automatic logic [DATA_W-1:0] byte_mask(input logic [IB_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < DATA_W / 8; i++) begin
            if (IB_W'(i) < n) begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/rfpp_ctrl.sv =====
// controller state machine: accepts a command and decides its outcome
module rfpp_ctrl
    import rfpp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_done
);

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd        = '0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                unique case (i_stat.op)
                    OP_PUT: begin
                        priority if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else if (i_stat.put_too_long) begin
                            o_cmd.status = ST_SIZE;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_adv  = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    OP_GET: begin
                        priority if (i_stat.room_short) begin
                            o_cmd.status = ST_SIZE;
                        end else if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.give_data = 1'b1;
                            o_cmd.rd_adv    = 1'b1;
                            o_cmd.cnt_dec   = 1'b1;
                        end
                    end
                    OP_PEEK: begin
                        if (i_stat.empty) o_cmd.status = ST_EMPTY;
                        else o_cmd.give_data = 1'b1;
                    end
                    OP_RELEASE: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.rd_adv  = 1'b1;
                            o_cmd.cnt_dec = 1'b1;
                        end
                    end
                    default: o_cmd.status = ST_OK;
                endcase
            end
            default: o_cmd.status = ST_OK;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ===== rtl/rfpp_dp.sv =====
// datapath: item store, slot pointers, count, high-water mark and config
module rfpp_dp
    import rfpp_pkg::*;
#(
    parameter int unsigned DEPTH          = 16,
    parameter int unsigned MAX_ITEM_BYTES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [1:0]            i_opcode,
    input  logic [DATA_W-1:0]     i_put_data,
    input  logic [IB_W-1:0]       i_put_bytes,
    input  logic [ROOM_W-1:0]     i_read_room_bytes,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data,
    output logic [1:0]            o_status,
    output logic [DATA_W-1:0]     o_read_data,
    output logic [CNT_W-1:0]      o_occupancy,
    output logic [CNT_W-1:0]      o_peak_occupancy
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CMP_W = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;
    localparam logic [CNT_W-1:0] CAP_RST = CNT_W'((DEPTH > 31) ? 31 : DEPTH);
    localparam logic [IB_W-1:0]  IB_MAX  = IB_W'(MAX_ITEM_BYTES);

    logic [DATA_W-1:0]    r_mem [DEPTH];
    logic [CNT_W-1:0]     r_capacity;
    logic [IB_W-1:0]      r_item_bytes;
    logic [PTR_W-1:0]     r_wr_slot;
    logic [PTR_W-1:0]     r_rd_slot;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_peak;
    logic [DATA_W-1:0]    r_rd_word;
    t_opcode              r_op;
    logic [DATA_W-1:0]    r_put_data;
    logic [IB_W-1:0]      r_put_bytes;
    logic [ROOM_W-1:0]    r_room;
    logic [1:0]           r_status;
    logic [DATA_W-1:0]    r_read_data;

    logic [CNT_W-1:0]     eff_cap;
    logic [IB_W-1:0]      eff_ib;
    logic [CNT_W-1:0]     n_count;
    logic [PTR_W-1:0]     n_wr_slot;
    logic [PTR_W-1:0]     n_rd_slot;

    always_comb begin
        if (r_capacity == '0) eff_cap = CNT_W'(1);
        else if (CMP_W'(r_capacity) > CMP_W'(CAP_RST)) eff_cap = CAP_RST;
        else eff_cap = r_capacity;
        if (r_item_bytes == '0) eff_ib = IB_W'(1);
        else if (r_item_bytes > IB_MAX) eff_ib = IB_MAX;
        else eff_ib = r_item_bytes;
    end

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] slot,
                                                  input logic [CNT_W-1:0] cap);
        logic [CMP_W-1:0] nxt;
        nxt = CMP_W'(slot) + CMP_W'(1);
        if (nxt >= CMP_W'(cap)) return '0;
        return nxt[PTR_W-1:0];
    endfunction

    assign n_wr_slot = advance(r_wr_slot, eff_cap);
    assign n_rd_slot = advance(r_rd_slot, eff_cap);
    assign n_count   = r_count + CNT_W'(1);

    assign o_stat.op           = r_op;
    assign o_stat.full         = (r_count >= eff_cap);
    assign o_stat.empty        = (r_count == '0);
    assign o_stat.put_too_long = (r_put_bytes > eff_ib);
    assign o_stat.room_short   = (r_room < ROOM_W'(eff_ib));

    // item store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_wr_slot] <= r_put_data & byte_mask(r_put_bytes);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_word <= r_mem[r_rd_slot];
        end
    end

    // latched command beat and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= t_opcode'(i_opcode);
            r_put_data  <= i_put_data;
            r_put_bytes <= i_put_bytes;
            r_room      <= i_read_room_bytes;
        end
        if (i_cmd.exec) begin
            r_status    <= i_cmd.status;
            r_read_data <= i_cmd.give_data ? (r_rd_word & byte_mask(eff_ib)) : '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAP_RST;
            r_item_bytes <= IB_MAX;
            r_wr_slot    <= '0;
            r_rd_slot    <= '0;
            r_count      <= '0;
            r_peak       <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_CAPACITY) begin
                r_capacity <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_ITEM_BYTES) begin
                r_item_bytes <= i_cfg_data[IB_W-1:0];
            end
            if (i_cmd.wr_adv) r_wr_slot <= n_wr_slot;
            if (i_cmd.rd_adv) r_rd_slot <= n_rd_slot;
            if (i_cmd.cnt_inc) begin
                r_count <= n_count;
                if (n_count > r_peak) r_peak <= n_count;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_status         = r_status;
    assign o_read_data      = r_read_data;
    assign o_occupancy      = r_count;
    assign o_peak_occupancy = r_peak;

endmodule

// ===== rtl/ring_fifo_with_peek_and_peak_core.sv =====
// top level of the ring fifo with peek and peak: controller plus datapath
//
// channels
//   command: drive i_opcode, i_put_data, i_put_bytes and i_read_room_bytes
//   with i_start high; the beat is taken at a rising edge where o_busy is low
//   result: o_done is high for exactly one cycle per command, with o_status,
//   o_read_data, o_occupancy and o_peak_occupancy valid in that cycle; the
//   receiver cannot hold results off, so there is no stall path
//   config: i_cfg_valid/o_cfg_ready (always high) with i_cfg_index
//   (0 capacity, 1 item size) and i_cfg_data; write only with nothing in flight
// timing
//   the accept edge registers the beat and reads the tail slot of the store,
//   the next edge commits pointers, count and store write and loads the result
//   registers; o_done is high in the cycle after that edge
//   the controller holds o_busy high for its single execute cycle, so a new
//   command can be taken at the edge that ends o_done
// reset
//   i_rst_n is synchronous, active low: pointers, count and high-water mark
//   clear, capacity returns to DEPTH capped at 31 and item size to
//   MAX_ITEM_BYTES; the item store is not cleared
module ring_fifo_with_peek_and_peak_core
    import rfpp_pkg::*;
#(
    parameter int unsigned DEPTH          = 16,
    parameter int unsigned MAX_ITEM_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command beat
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_opcode,
    input  logic [63:0]          i_put_data,
    input  logic [3:0]           i_put_bytes,
    input  logic [7:0]           i_read_room_bytes,
    // result beat
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic [63:0]          o_read_data,
    output logic [4:0]           o_occupancy,
    output logic [4:0]           o_peak_occupancy,
    // config write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [4:0]           i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // config writes never wait
    assign o_cfg_ready = 1'b1;

    rfpp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    rfpp_dp #(
        .DEPTH          (DEPTH),
        .MAX_ITEM_BYTES (MAX_ITEM_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_opcode          (i_opcode),
        .i_put_data        (i_put_data),
        .i_put_bytes       (i_put_bytes),
        .i_read_room_bytes (i_read_room_bytes),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_status          (o_status),
        .o_read_data       (o_read_data),
        .o_occupancy       (o_occupancy),
        .o_peak_occupancy  (o_peak_occupancy)
    );

endmodule

// ===== rtl/rfpp_chk.sv =====
// port-level checker for the ring fifo core, with its bind
module rfpp_chk
    import rfpp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [63:0] o_read_data,
    input logic [4:0]  o_occupancy,
    input logic [4:0]  o_peak_occupancy
);

    // an accepted beat keeps the block busy for one cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted command did not raise busy");

    // busy always ends in a result strobe
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> o_done)
        else $error("busy cycle not followed by result");

    // failed commands return no data
    a_err_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_read_data == '0))
        else $error("read data on error result");

    // failed commands leave occupancy alone
    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_occupancy == $past(o_occupancy)))
        else $error("occupancy changed on error result");

    // high-water mark never below occupancy
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_peak_occupancy >= o_occupancy))
        else $error("peak below occupancy");

endmodule

bind ring_fifo_with_peek_and_peak_core rfpp_chk u_rfpp_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (i_start),
    .o_busy           (o_busy),
    .o_done           (o_done),
    .o_status         (o_status),
    .o_read_data      (o_read_data),
    .o_occupancy      (o_occupancy),
    .o_peak_occupancy (o_peak_occupancy)
);

// ===== tb/ring_fifo_with_peek_and_peak_core_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the ring fifo with peek and peak core
module ring_fifo_with_peek_and_peak_core_test;
    import rfpp_pkg::*;

    localparam int unsigned SLOTS           = 16;
    localparam int unsigned ITEM_MAX        = 8;
    // extra wait in settle once the last reply is back
    localparam int unsigned DRAIN_WAIT      = 4;
    localparam int unsigned QUIET_LIMIT     = 2000;
    localparam int unsigned ITEMS_PER_PHASE = 130;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam logic [63:0] ALL_ONES = '1;

    // settings per random phase, first phase in the low bits
    // capacity: 16, 1, 31 (acts as 16), 0 (acts as 1), 5, 17 (acts as 16), 2, 16
    localparam logic [8*5-1:0] PHASE_CAPS =
        {5'd16, 5'd2, 5'd17, 5'd5, 5'd0, 5'd31, 5'd1, 5'd16};
    // item size: 8, 1, 31 (low nibble 15, acts as 8), 0 (acts as 1), 3, 9, 8, 5
    localparam logic [8*5-1:0] PHASE_IBS =
        {5'd5, 5'd8, 5'd9, 5'd3, 5'd0, 5'd31, 5'd1, 5'd8};

    typedef struct packed {
        t_opcode     op;
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic [7:0]  room;
    } t_fifo_cmd;

    typedef struct packed {
        t_status     status;
        logic [63:0] data;
        logic [4:0]  occ;
        logic [4:0]  peak;
    } t_fifo_reply;

    // stimulus side, all known from time zero
    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_start           = 1'b0;
    logic [1:0]  i_opcode          = '0;
    logic [63:0] i_put_data        = '0;
    logic [3:0]  i_put_bytes       = '0;
    logic [7:0]  i_read_room_bytes = '0;
    logic        i_cfg_valid       = 1'b0;
    logic [1:0]  i_cfg_index       = '0;
    logic [4:0]  i_cfg_data        = '0;

    logic        o_busy;
    logic        o_done;
    logic [1:0]  o_status;
    logic [63:0] o_read_data;
    logic [4:0]  o_occupancy;
    logic [4:0]  o_peak_occupancy;
    logic        o_cfg_ready;

    // shadow copy of the fifo, updated at each accepted beat
    logic [63:0] sh_store [SLOTS];
    bit          sh_written [SLOTS];
    logic [3:0]  sh_wr_slot;
    logic [3:0]  sh_rd_slot;
    logic [4:0]  sh_count;
    logic [4:0]  sh_peak;
    logic [4:0]  sh_capacity;
    logic [3:0]  sh_item_bytes;

    // replies owed by the core, oldest first
    t_fifo_reply replies_due [$];
    int unsigned n_fail       = 0;
    int unsigned quiet_cycles = 0;

    ring_fifo_with_peek_and_peak_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_opcode          (i_opcode),
        .i_put_data        (i_put_data),
        .i_put_bytes       (i_put_bytes),
        .i_read_room_bytes (i_read_room_bytes),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_read_data       (o_read_data),
        .o_occupancy       (o_occupancy),
        .o_peak_occupancy  (o_peak_occupancy),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // zero acts as one slot, anything past the store acts as the full store
    function automatic logic [4:0] live_capacity();
        if (sh_capacity == 5'd0) begin
            return 5'd1;
        end
        if (sh_capacity > SLOTS) begin
            return 5'(SLOTS);
        end
        return sh_capacity;
    endfunction

    // same clamping for the item size
    function automatic logic [3:0] live_item_bytes();
        if (sh_item_bytes == 4'd0) begin
            return 4'd1;
        end
        if (sh_item_bytes > ITEM_MAX) begin
            return 4'(ITEM_MAX);
        end
        return sh_item_bytes;
    endfunction

    function automatic logic [63:0] low_bytes(input int n);
        if (n >= 8) begin
            return '1;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // a slot wraps once it reaches the capacity in force, even if it sat beyond it
    function automatic logic [3:0] next_slot(input logic [3:0] s);
        int n;
        n = int'(s) + 1;
        if (n >= int'(live_capacity())) begin
            n = 0;
        end
        return 4'(n);
    endfunction

    // work out the reply to one command and move the shadow state on
    task automatic apply_fifo_op(input t_fifo_cmd c);
        t_fifo_reply r;
        logic [3:0]  ib;
        ib       = live_item_bytes();
        r.status = ST_OK;
        r.data   = '0;
        case (c.op)
            OP_PUT: begin
                // full is checked before length
                if (sh_count >= live_capacity()) begin
                    r.status = ST_FULL;
                end else if (c.nbytes > ib) begin
                    r.status = ST_SIZE;
                end else begin
                    sh_store[sh_wr_slot]   = c.data & low_bytes(c.nbytes);
                    sh_written[sh_wr_slot] = 1'b1;
                    sh_wr_slot             = next_slot(sh_wr_slot);
                    sh_count               = sh_count + 5'd1;
                    if (sh_count > sh_peak) begin
                        sh_peak = sh_count;
                    end
                end
            end
            OP_GET: begin
                // reader room is checked before empty
                if (c.room < ib) begin
                    r.status = ST_SIZE;
                end else if (sh_count == 5'd0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data     = sh_store[sh_rd_slot] & low_bytes(ib);
                    sh_rd_slot = next_slot(sh_rd_slot);
                    sh_count   = sh_count - 5'd1;
                end
            end
            OP_PEEK: begin
                if (sh_count == 5'd0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = sh_store[sh_rd_slot] & low_bytes(ib);
                end
            end
            default: begin
                if (sh_count == 5'd0) begin
                    r.status = ST_EMPTY;
                end else begin
                    sh_rd_slot = next_slot(sh_rd_slot);
                    sh_count   = sh_count - 5'd1;
                end
            end
        endcase
        r.occ  = sh_count;
        r.peak = sh_peak;
        replies_due.push_back(r);
    endtask

    function automatic t_fifo_cmd make_cmd(input t_opcode op, input logic [63:0] data,
                                           input logic [3:0] nbytes, input logic [7:0] room);
        t_fifo_cmd c;
        c.op     = op;
        c.data   = data;
        c.nbytes = nbytes;
        c.room   = room;
        return c;
    endfunction

    // one command beat; start is left high when the next beat follows at once
    task automatic send_cmd(input t_fifo_cmd c, input int unsigned gap);
        // after a resize the tail may sit on a slot never written: read it not
        if (sh_count != 5'd0 && !sh_written[sh_rd_slot] &&
            (c.op == OP_PEEK || (c.op == OP_GET && c.room >= live_item_bytes()))) begin
            c.op = OP_RELEASE;
        end
        i_start           <= 1'b1;
        i_opcode          <= c.op;
        i_put_data        <= c.data;
        i_put_bytes       <= c.nbytes;
        i_read_room_bytes <= c.room;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        apply_fifo_op(c);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every reply is back and the core has gone quiet
    task automatic settle();
        i_start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // capacity then item size, optionally a beat to an unmapped index as well
    task automatic write_config(input logic [4:0] cap, input logic [4:0] ib, input bit poke);
        logic [1:0] idx;
        logic [4:0] val;
        int         beats;
        beats = poke ? 3 : 2;
        for (int b = 0; b < beats; b++) begin
            idx = (b == 0) ? CFG_CAPACITY : (b == 1) ? CFG_ITEM_BYTES : CFG_UNMAPPED;
            val = (b == 0) ? cap : (b == 1) ? ib : 5'h0a;
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            case (idx)
                CFG_CAPACITY:   sh_capacity = val;
                CFG_ITEM_BYTES: sh_item_bytes = val[3:0];
                default:        ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_fifo_cmd random_cmd(input int unsigned put_pct);
        t_fifo_cmd   c;
        int unsigned ib;
        int unsigned pick;
        ib     = live_item_bytes();
        c.data = {$urandom, $urandom};
        pick   = $urandom_range(99);
        if (pick < put_pct) begin
            c.op = OP_PUT;
        end else begin
            pick = $urandom_range(9);
            c.op = (pick < 6) ? OP_GET : (pick < 8) ? OP_PEEK : OP_RELEASE;
        end
        // mostly lengths that fit, often the full item, now and then too long
        pick = $urandom_range(99);
        if (pick < 40) begin
            c.nbytes = 4'(ib);
        end else if (pick < 85) begin
            c.nbytes = 4'($urandom_range(ib));
        end else begin
            c.nbytes = 4'($urandom_range(15));
        end
        // mostly enough room, some short, some anywhere in the byte
        pick = $urandom_range(99);
        if (pick < 80) begin
            c.room = 8'(ib + $urandom_range(4));
        end else if (pick < 88) begin
            c.room = 8'($urandom_range(ib - 1));
        end else begin
            c.room = 8'($urandom_range(255));
        end
        return c;
    endfunction

    function automatic int unsigned pick_gap(input int unsigned idle_pct);
        int unsigned g;
        g = 0;
        while (g < 24 && $urandom_range(99) < idle_pct) begin
            g++;
        end
        return g;
    endfunction

    // get, peek and release on an empty fifo; room short beats empty for get
    task automatic test_empty_errors();
        send_cmd(make_cmd(OP_GET, ALL_ONES, 4'd0, 8'd255), 0);
        send_cmd(make_cmd(OP_GET, '0, 4'd8, 8'd0), 1);
        send_cmd(make_cmd(OP_PEEK, ALL_ONES, 4'd15, 8'd8), 0);
        send_cmd(make_cmd(OP_RELEASE, '0, 4'd0, 8'd0), 2);
    endtask

    // full, empty and partial lengths, and lengths past eight
    task automatic test_put_lengths();
        send_cmd(make_cmd(OP_PUT, ALL_ONES, 4'd8, 8'd0), 0);
        send_cmd(make_cmd(OP_PUT, ALL_ONES, 4'd0, 8'd255), 0);
        send_cmd(make_cmd(OP_PUT, 64'h0123_4567_89ab_cdef, 4'd3, 8'd0), 1);
        send_cmd(make_cmd(OP_PUT, ALL_ONES, 4'd9, 8'd0), 0);
        send_cmd(make_cmd(OP_PUT, ALL_ONES, 4'd15, 8'd0), 0);
    endtask

    // peek leaves the tail, get needs room for a whole item, then drain
    task automatic test_tail_reads();
        send_cmd(make_cmd(OP_PEEK, '0, 4'd0, 8'd0), 0);
        send_cmd(make_cmd(OP_GET, '0, 4'd0, 8'd7), 0);
        send_cmd(make_cmd(OP_GET, '0, 4'd0, 8'd8), 3);
        send_cmd(make_cmd(OP_GET, '0, 4'd0, 8'd255), 0);
        send_cmd(make_cmd(OP_RELEASE, '0, 4'd0, 8'd0), 0);
        send_cmd(make_cmd(OP_RELEASE, '0, 4'd0, 8'd0), 0);
    endtask

    // zero capacity and zero item size act as one; full is reported before length
    task automatic test_full_before_size();
        settle();
        write_config(5'd0, 5'd0, 1'b0);
        send_cmd(make_cmd(OP_PUT, 64'hfedc_ba98_7654_3210, 4'd1, 8'd0), 0);
        send_cmd(make_cmd(OP_PUT, ALL_ONES, 4'd15, 8'd0), 0);
        send_cmd(make_cmd(OP_GET, '0, 4'd0, 8'd0), 0);
        send_cmd(make_cmd(OP_GET, '0, 4'd0, 8'd1), 0);
        send_cmd(make_cmd(OP_PUT, ALL_ONES, 4'd2, 8'd0), 0);
    endtask

    // shrink below the count: puts see full, reads wrap and come back masked
    task automatic test_resize_with_items_held();
        settle();
        write_config(5'd16, 5'd8, 1'b0);
        repeat (3) send_cmd(make_cmd(OP_PUT, {$urandom, $urandom}, 4'd8, 8'd0), 0);
        settle();
        write_config(5'd2, 5'd4, 1'b0);
        send_cmd(make_cmd(OP_PUT, ALL_ONES, 4'd1, 8'd0), 0);
        repeat (3) send_cmd(make_cmd(OP_GET, '0, 4'd0, 8'd4), 0);
    endtask

    // random traffic through a run of settings; contents survive each change
    task automatic test_random_traffic();
        int unsigned idle_pct;
        int unsigned put_pct;
        for (int p = 0; p < 8; p++) begin
            settle();
            write_config(PHASE_CAPS[p*5 +: 5], PHASE_IBS[p*5 +: 5], p == 3);
            idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 57 : 10;
            put_pct  = 50;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // swing the put bias so the fifo both fills and empties
                if (n % 20 == 0) begin
                    case ($urandom_range(3))
                        0:       put_pct = 25;
                        1:       put_pct = 50;
                        2:       put_pct = 75;
                        default: put_pct = 92;
                    endcase
                end
                // halfway through, the sender waits for every reply
                if (n == ITEMS_PER_PHASE / 2) begin
                    settle();
                end
                send_cmd(random_cmd(put_pct), pick_gap(idle_pct));
            end
        end
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        n_fail++;
    endtask

    // each done strobe is one result beat, checked against the oldest reply owed
    always @(posedge i_clk) begin : check_replies
        t_fifo_reply want;
        if (i_rst_n && o_done === 1'b1) begin
            if (replies_due.size() == 0) begin
                $display("%0t: result beat with nothing owed, status %0d data %h",
                         $time, o_status, o_read_data);
                n_fail++;
            end else begin
                want = replies_due.pop_front();
                if (o_status !== want.status) begin
                    note_mismatch("status", 64'(want.status), 64'(o_status));
                end
                if (o_read_data !== want.data) begin
                    note_mismatch("read data", want.data, o_read_data);
                end
                if (o_occupancy !== want.occ) begin
                    note_mismatch("occupancy", 64'(want.occ), 64'(o_occupancy));
                end
                if (o_peak_occupancy !== want.peak) begin
                    note_mismatch("peak occupancy", 64'(want.peak), 64'(o_peak_occupancy));
                end
            end
        end
    end

    // watchdog: too long with no beat on any channel ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && o_busy === 1'b0) || o_done === 1'b1 ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            sh_store[s]   = '0;
            sh_written[s] = 1'b0;
        end
        sh_wr_slot    = '0;
        sh_rd_slot    = '0;
        sh_count      = '0;
        sh_peak       = '0;
        sh_capacity   = 5'(SLOTS);
        sh_item_bytes = 4'(ITEM_MAX);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_errors();
        test_put_lengths();
        test_tail_reads();
        test_full_before_size();
        test_resize_with_items_held();
        test_random_traffic();

        settle();
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rfpp_pkg.sv
rtl/rfpp_ctrl.sv
rtl/rfpp_dp.sv
rtl/ring_fifo_with_peek_and_peak_core.sv
rtl/rfpp_chk.sv
tb/ring_fifo_with_peek_and_peak_core_test.sv
